// File: sv/prrc_pkg.sv
// prrc_pkg: shared constants, types and codes for the page reverse map block
// used by prrc_ctrl, prrc_datapath and page_reverse_map_refcount_top; no dependencies
package prrc_pkg;

  localparam int PAGES      = 4096;
  localparam int SLOTS      = 16;
  localparam int PAGE_NUM_W = 12;
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 16;
  localparam int PAGE_AW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SLOT_IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // request layout: action, page_number, mapping_tag; padded to whole bytes
  localparam int S_FIELDS_W = 2 + PAGE_NUM_W + TAG_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  // result layout: five fields, padded to whole bytes
  localparam int M_FIELDS_W = 4 + CNT_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // per-page bookkeeping row
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SLOTS-1:0] valid;
  } meta_t;

  // packed result, last field in the lowest bit
  typedef struct packed {
    logic [CNT_W-1:0] reference_count;
    logic             table_full;
    logic             not_found_error;
    logic             sole_owner;
    logic             now_unreferenced;
  } result_t;

  typedef struct packed {
    logic load;   // take the request and read its page row
    logic clr;    // clear one page row of the bookkeeping memory
    logic exec;   // update the row and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: sv/page_reverse_map_refcount_top.sv
// page_reverse_map_refcount_top: reverse map of physical pages with reference counts
// depends on prrc_pkg, prrc_ctrl and prrc_datapath
//
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata: add a mapping tag to a page,
//   remove one, or query whether the page has a single owner. Each request
//   gives exactly one result on m_tvalid/m_tready/m_tdata: the page's count
//   after the request plus the unreferenced, sole owner, not found and full flags.
//   A request first reads the page row (count, valid bits and all tags of the
//   page from their row memories), then compares tags across the slots, writes
//   the row back and loads the result register. A new request is taken only
//   after the previous one is updated; the result register lets the next request
//   be read while the previous result still waits. m_tvalid rises as the update
//   loads the result register.
//   If the receiver stalls with a result pending, the next request waits in its
//   update cycle until the register frees, and s_tready stays low meanwhile.
//   After rst the block sweeps the count/valid memory, one page a cycle, over all
//   PAGES (4096) pages with s_tready low; tags are not cleared since they are
//   read only behind a valid bit.
module page_reverse_map_refcount_top
  import prrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // action[1:0], page_number[13:2], mapping_tag[45:14], zero fill above
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // now_unreferenced[0], sole_owner[1], not_found_error[2], table_full[3],
  // reference_count[19:4], zero fill above
  output logic [M_DATA_W-1:0] m_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  prrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prrc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: sv/prrc_ctrl.sv
// prrc_ctrl: sequencer for the reset clearing pass and the per-request read/update
// depends on prrc_pkg
module prrc_ctrl
  import prrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold the update until the result register can take it
        if (!stat.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: sv/prrc_datapath.sv
// prrc_datapath: page row memories, slot search, count update and result register
// depends on prrc_pkg; driven by prrc_ctrl commands
module prrc_datapath
  import prrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  meta_t                 meta_mem [PAGES];
  logic [SLOTS-1:0][TAG_W-1:0] tag_mem [PAGES];

  logic [PAGE_AW-1:0]    clr_cnt;
  logic [1:0]            req_action;
  logic [PAGE_AW-1:0]    req_page;
  logic [TAG_W-1:0]      req_tag;
  logic                  req_oor;
  meta_t                 meta_rd;
  logic [SLOTS-1:0][TAG_W-1:0] tag_row;
  result_t               result;

  logic [1:0]            in_action;
  logic [PAGE_NUM_W-1:0] in_page;
  logic [TAG_W-1:0]      in_tag;
  logic [PAGE_AW-1:0]    load_addr;

  logic [SLOTS-1:0]      free_vec;
  logic [SLOTS-1:0]      match_vec;
  logic [SLOT_IW-1:0]    free_idx;
  logic [SLOT_IW-1:0]    match_idx;
  meta_t                 meta_new;
  result_t               result_new;
  logic                  tag_we;
  logic                  meta_we;
  logic [PAGE_AW-1:0]    meta_waddr;
  meta_t                 meta_wdata;

  assign in_action = s_tdata[1:0];
  assign in_page   = s_tdata[PAGE_NUM_W+1:2];
  assign in_tag    = s_tdata[PAGE_NUM_W+TAG_W+1:PAGE_NUM_W+2];
  assign load_addr = PAGE_AW'(in_page);

  assign stat.clr_last = (32'(clr_cnt) == PAGES - 1);
  assign stat.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= in_action;
      req_page   <= load_addr;
      req_tag    <= in_tag;
      req_oor    <= (32'(in_page) >= PAGES);
    end
  end

  // slot search over the row read for this request
  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      free_vec[s]  = !meta_rd.valid[s];
      match_vec[s] = meta_rd.valid[s] && (tag_row[s] == req_tag);
    end
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (free_vec[s]) begin
        free_idx = SLOT_IW'(s);
      end
      if (match_vec[s]) begin
        match_idx = SLOT_IW'(s);
      end
    end
  end

  always_comb begin
    meta_new   = meta_rd;
    result_new = '0;
    tag_we     = 1'b0;
    unique case (req_action)
      ACT_ADD: begin
        if (meta_rd.count != CNT_MAX) begin
          meta_new.count = meta_rd.count + 1'b1;
        end
        if (|free_vec) begin
          meta_new.valid[free_idx] = 1'b1;
          tag_we = 1'b1;
        end else begin
          result_new.table_full = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (|match_vec) begin
          meta_new.valid[match_idx] = 1'b0;
          if (meta_rd.count != '0) begin
            meta_new.count = meta_rd.count - 1'b1;
          end
          result_new.now_unreferenced = (meta_new.count == '0);
        end else begin
          result_new.not_found_error = 1'b1;
        end
      end
      default: begin
        // query, and the unused code behaves the same
      end
    endcase
    result_new.reference_count = meta_new.count;
    result_new.sole_owner      = (meta_new.count == CNT_W'(1));
    if (req_oor) begin
      result_new = '0;
      tag_we     = 1'b0;
    end
  end

  assign meta_we    = cmd.clr || (cmd.exec && !req_oor);
  assign meta_waddr = cmd.clr ? clr_cnt : req_page;
  assign meta_wdata = cmd.clr ? meta_t'('0) : meta_new;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (cmd.load) begin
      meta_rd <= meta_mem[load_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && tag_we) begin
      tag_mem[req_page][free_idx] <= req_tag;
    end
    if (cmd.load) begin
      tag_row <= tag_mem[load_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= result_new;
    end
  end

  assign m_tdata = M_DATA_W'(result);

  a_no_exec_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !stat.out_busy)
    else $error("result register overwritten while stalled");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr && (cmd.exec || cmd.load)))
    else $error("request handled during clearing pass");

  a_miss_keeps_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && result_new.not_found_error) |-> (meta_new == meta_rd))
    else $error("failed remove changed the page row");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (meta_new.count == meta_rd.count ||
                  meta_new.count == meta_rd.count + 1'b1 ||
                  meta_new.count == meta_rd.count - 1'b1))
    else $error("reference count moved by more than one");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_tvalid)
    else $error("result not presented after update");

endmodule
